FILE: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // one classified request passed from front to back
   typedef struct packed {
      logic       finish;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

FILE: sv/sha_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sha_cmd_fifo
// Short queue of classified requests between the front and the core.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_cmd_fifo (
   input  wire              clock,
   input  wire              reset,
   input  wire              wr_valid,
   output logic             wr_ready,
   input  sha_pkg::cmd_type wr_data,
   output logic             rd_valid,
   input  wire              rd_ready,
   output sha_pkg::cmd_type rd_data
);
   import sha_pkg::*;

   cmd_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       wr_go, rd_go;

   assign wr_ready = (cnt_ff != 3'd4);
   assign rd_valid = (cnt_ff != 3'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr_go    = wr_valid && wr_ready;
   assign rd_go    = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wr_go ? wp_ff + 2'd1 : wp_ff;
      rp_in  = rd_go ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, wr_go} - {2'd0, rd_go};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr_go) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

FILE: sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Block buffer, padding sequencer, one-round-per-cycle compression, digest out.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
   input  wire              clock,
   input  wire              reset,
   input  wire              cmd_valid,
   output logic             cmd_ready,
   input  sha_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   output logic             busy
);
   import sha_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PAD  = 5'b00010,
      ST_RUN  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] buf_ff [16];          // block as 16 big-endian words
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff;               // compression belongs to a finish
   logic        last_ff;              // this is the final block of a finish
   logic [2:0]  oidx_ff;

   logic        take;
   logic [31:0] wt, t1, t2, s0, s1, ee, aa;
   logic [3:0]  widx;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign busy      = (state_ff != ST_IDLE);
   assign widx      = rnd_ff[3:0];

   always_comb begin
      s1 = rotr(w_ff[widx - 4'd2], 17) ^ rotr(w_ff[widx - 4'd2], 19)
           ^ (w_ff[widx - 4'd2] >> 10);
      s0 = rotr(w_ff[widx - 4'd15], 7) ^ rotr(w_ff[widx - 4'd15], 18)
           ^ (w_ff[widx - 4'd15] >> 3);
      wt = (rnd_ff < 6'd16) ? buf_ff[widx]
           : s1 + w_ff[widx - 4'd7] + s0 + w_ff[widx];
      ee = v_ff[4];
      aa = v_ff[0];
      t1 = v_ff[7] + (rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25))
           + (v_ff[6] ^ (ee & (v_ff[5] ^ v_ff[6]))) + ROUND_K[rnd_ff] + wt;
      t2 = (rotr(aa, 2) ^ rotr(aa, 13) ^ rotr(aa, 22))
           + ((aa & (v_ff[1] | v_ff[2])) | (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            if (cmd_data.finish == ACT_FINISH) state_in = ST_PAD;
            else if (fill_ff == 6'd63)         state_in = ST_RUN;
         end
         ST_PAD:  state_in = ST_RUN;
         ST_RUN:  if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (!fin_ff)      state_in = ST_IDLE;
            else if (last_ff) state_in = ST_OUT;
            else              state_in = ST_PAD;
         end
         ST_OUT:  if (rsp_ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         oidx_ff  <= '0;
         rnd_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (take) begin
               if (cmd_data.finish == ACT_FINISH) begin
                  fin_ff  <= 1'b1;
                  last_ff <= 1'b0;
                  // place 0x80 marker, clear rest of the current word
                  for (int b = 0; b < 4; b++)
                     if (fill_ff[1:0] == 2'(b))
                        buf_ff[fill_ff[5:2]][31-8*b -: 8] <= 8'h80;
                     else if (fill_ff[1:0] < 2'(b))
                        buf_ff[fill_ff[5:2]][31-8*b -: 8] <= 8'h00;
               end else begin
                  fin_ff <= 1'b0;
                  buf_ff[fill_ff[5:2]][31-8*fill_ff[1:0] -: 8] <= cmd_data.data;
                  bits_ff <= bits_ff + 64'd8;
                  fill_ff <= fill_ff + 6'd1;
               end
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_PAD: begin
               // first pad: clear words after marker; second block: all zero
               for (int j = 0; j < 16; j++) begin
                  if (last_ff || j > int'(fill_ff[5:2]))
                     buf_ff[j] <= 32'd0;
               end
               if (last_ff || fill_ff < 6'd56) begin
                  buf_ff[14] <= bits_ff[63:32];
                  buf_ff[15] <= bits_ff[31:0];
                  last_ff    <= 1'b1;
               end
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_RUN: begin
               w_ff[widx] <= wt;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 6'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (fin_ff && !last_ff) last_ff <= 1'b1;
               oidx_ff <= '0;
            end
            ST_OUT: if (rsp_ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
                  fill_ff <= '0;
                  bits_ff <= '0;
                  fin_ff  <= 1'b0;
                  last_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = h_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);
endmodule
`default_nettype wire

FILE: sv/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Byte-stream SHA-256 hasher with a request queue in front of the core.
// ----------------------------------------------------------------------------
// An absorb request carries one byte, which the core writes into the block
// buffer; the 64th byte of a block also starts a compression (one round
// per cycle plus the chaining add). A finish request pads, compresses
// one or two blocks and then offers the eight digest words, index 0
// first. The four-entry request queue lets requests arrive while the core
// compresses. The round datapath sets the throughput.
`default_nettype none
module sha256_stream_hasher_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_action,
   input  wire  [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready, core_busy;

   assign in_cmd.finish = req_action;
   assign in_cmd.data   = req_data_byte;

   sha_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_valid(req_valid), .wr_ready(req_ready), .wr_data(in_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   sha_core u_core (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word), .busy(core_busy)
   );

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word mismatch");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      core_busy |-> !q_ready)
      else $error("core took a request while busy");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word)
      |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word order broken");
endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-256 stream hasher: messages of random length
// and content are streamed in and every digest word is checked against a
// behavioral hash computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class digest_scoreboard;
   logic [31:0] chain [8];
   logic [7:0]  buffer [64];
   int          fill;
   logic [63:0] bit_len;
   logic [31:0] digest_q [$];
   logic [2:0]  index_q [$];
   logic        last_q [$];
   int          errors;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_HASH[i];
      fill = 0;
      bit_len = '0;
   endfunction

   function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {buffer[4*t], buffer[4*t+1], buffer[4*t+2], buffer[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::ROUND_K[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & (v[1] | v[2])) | (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   function void note_request(logic action, logic [7:0] data);
      if (action == sha_pkg::ACT_ABSORB) begin
         buffer[fill] = data;
         bit_len += 8;
         fill = (fill + 1) % 64;
         if (fill == 0) compress();
         return;
      end
      buffer[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
         while (fill < 64) buffer[fill++] = 8'h00;
         compress();
         fill = 0;
      end
      while (fill < 56) buffer[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) buffer[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         digest_q.push_back(chain[i]);
         index_q.push_back(i[2:0]);
         last_q.push_back(i == 7);
      end
      restart();
   endfunction

   function void check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
      if (digest_q.size() == 0) begin
         $error("digest word %h with nothing pending", dw);
         errors++;
         return;
      end
      if (digest_q[0] !== dw) begin
         $error("digest_word expected %h actual %h", digest_q[0], dw); errors++;
      end
      if (index_q[0] !== idx) begin
         $error("word_index expected %0d actual %0d", index_q[0], idx); errors++;
      end
      if (last_q[0] !== lw) begin
         $error("last_word expected %0d actual %0d", last_q[0], lw); errors++;
      end
      void'(digest_q.pop_front()); void'(index_q.pop_front());
      void'(last_q.pop_front());
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          cycle_count = 0;
   digest_scoreboard hash_sb = new();

   always #4 clock = ~clock;

   sha256_stream_hasher_unit u_top (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // one request; idle gap first, then hold valid until accepted
   task automatic send_request(logic action, logic [7:0] data, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      hash_sb.note_request(action, data);
   endtask

   task automatic send_message(int len, int mode, bit burst);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_request(sha_pkg::ACT_ABSORB, b, burst);
      end
      send_request(sha_pkg::ACT_FINISH, 8'($urandom_range(0, 255)), burst);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (hash_sb.digest_q.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            hash_sb.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
         if ($urandom_range(0, 99) < 8)
            rsp_ready <= 1'b0;
         else if ($urandom_range(0, 99) < 70)
            rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message, edge lengths around padding spill, all-ones
      send_message(0, 2, 0);
      send_message(3, 1, 1);
      send_message(55, 0, 0);
      send_message(56, 1, 1);
      send_message(64, 2, 0);
      drain();
      // sender does not wait for the digest words before the next message
      send_message(1, 1, 0);
      send_message(2, 0, 0);
      // a few short random messages
      n = 0;
      while (n < 12) begin
         int len;
         len = $urandom_range(0, 5);
         send_message(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2,
                      $urandom_range(0, 3) == 0);
         n += len + 1;
      end
      // random bytes with a finish stray between absorbs as noise
      for (int i = 0; i < 10; i++)
         send_request($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));
      send_request(sha_pkg::ACT_FINISH, 8'h00);
      drain();
      repeat (300) @(posedge clock);
      if (hash_sb.errors == 0 && hash_sb.digest_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
